@@ sv/dpsd_pkg.sv @@
// shared types and constants for the dive profile sample decoder
package dpsd_pkg;

  localparam int unsigned MAX_GAS_MIXES = 3;
  localparam int unsigned GAS_CNT_W = $clog2(MAX_GAS_MIXES + 1);
  localparam int unsigned GAS_IDX_W = (MAX_GAS_MIXES > 1) ? $clog2(MAX_GAS_MIXES) : 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NUM_SLOTS = 9;

  localparam logic [7:0] BYTE_CODE_LO      = 8'h79;
  localparam logic [7:0] BYTE_EV_ASCENT    = 8'h7a;
  localparam logic [7:0] BYTE_EV_VIOLATION = 8'h7b;
  localparam logic [7:0] BYTE_EV_BOOKMARK  = 8'h7c;
  localparam logic [7:0] BYTE_EV_SURFACE   = 8'h7d;
  localparam logic [7:0] BYTE_EV_DECO      = 8'h7e;
  localparam logic [7:0] BYTE_EV_CEILING   = 8'h7f;
  localparam logic [7:0] BYTE_END          = 8'h80;
  localparam logic [7:0] BYTE_EV_SAFETY    = 8'h81;
  localparam logic [7:0] BYTE_GAS_CHANGE   = 8'h87;
  localparam logic [7:0] AIR_OXYGEN        = 8'd21;

  localparam logic [7:0] SAMPLE_INTERVAL_RST = 8'd20;

  typedef enum logic [1:0] {
    CFG_SAMPLE_INTERVAL = 2'd0,
    CFG_GAUGE_MODE      = 2'd1,
    CFG_FIRST_OXYGEN    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_TIME    = 3'd0,
    KIND_DEPTH   = 3'd1,
    KIND_GAS     = 3'd2,
    KIND_EVENT   = 3'd3,
    KIND_ERROR   = 3'd4,
    KIND_SUMMARY = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    EV_ASCENT      = 3'd0,
    EV_VIOLATION   = 3'd1,
    EV_BOOKMARK    = 3'd2,
    EV_SURFACE     = 3'd3,
    EV_DECO        = 3'd4,
    EV_CEILING     = 3'd5,
    EV_SAFETY_STOP = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    ERR_TRUNC_GAS = 2'd0,
    ERR_GAS_FULL  = 2'd1,
    ERR_NO_END    = 2'd2
  } error_e;

  typedef enum logic [2:0] {
    CLS_DELTA,
    CLS_END,
    CLS_EVENT,
    CLS_GAS_CHANGE,
    CLS_OTHER
  } byte_class_e;

  // result slots in emission order
  typedef enum logic [3:0] {
    S_TIME0   = 4'd0,
    S_DEPTH0  = 4'd1,
    S_GAS0    = 4'd2,
    S_TIME    = 4'd3,
    S_DEPTH   = 4'd4,
    S_EVENT   = 4'd5,
    S_GAS     = 4'd6,
    S_SUMMARY = 4'd7,
    S_ERROR   = 4'd8
  } slot_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       buffer_end;
  } in_word_t;

  typedef struct packed {
    kind_e              kind;
    logic [23:0]        time_seconds;
    logic signed [15:0] depth_feet;
    logic [1:0]         gas_index;
    logic [2:0]         event_code;
    logic [1:0]         error_code;
    logic               last_result;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        buffer_end;
    byte_class_e cls;
    event_e      ev_code;
  } cmd_t;

endpackage

@@ sv/dpsd_front.sv @@
// front end: classifies each profile byte into a command word
module dpsd_front
  import dpsd_pkg::*;
(
  input  in_word_t in_word_i,
  output cmd_t     cmd_o
);

  always_comb begin
    cmd_o.data_byte  = in_word_i.data_byte;
    cmd_o.first_byte = in_word_i.first_byte;
    cmd_o.buffer_end = in_word_i.buffer_end;
    cmd_o.cls        = CLS_DELTA;
    cmd_o.ev_code    = EV_ASCENT;
    case (in_word_i.data_byte) inside
      BYTE_END:          cmd_o.cls = CLS_END;
      BYTE_GAS_CHANGE:   cmd_o.cls = CLS_GAS_CHANGE;
      BYTE_EV_ASCENT: begin
        cmd_o.cls     = CLS_EVENT;
        cmd_o.ev_code = EV_ASCENT;
      end
      BYTE_EV_VIOLATION: begin
        cmd_o.cls     = CLS_EVENT;
        cmd_o.ev_code = EV_VIOLATION;
      end
      BYTE_EV_BOOKMARK: begin
        cmd_o.cls     = CLS_EVENT;
        cmd_o.ev_code = EV_BOOKMARK;
      end
      BYTE_EV_SURFACE: begin
        cmd_o.cls     = CLS_EVENT;
        cmd_o.ev_code = EV_SURFACE;
      end
      BYTE_EV_DECO: begin
        cmd_o.cls     = CLS_EVENT;
        cmd_o.ev_code = EV_DECO;
      end
      BYTE_EV_CEILING: begin
        cmd_o.cls     = CLS_EVENT;
        cmd_o.ev_code = EV_CEILING;
      end
      BYTE_EV_SAFETY: begin
        cmd_o.cls     = CLS_EVENT;
        cmd_o.ev_code = EV_SAFETY_STOP;
      end
      // unknown codes inside the event range
      [BYTE_CODE_LO:BYTE_GAS_CHANGE]: cmd_o.cls = CLS_OTHER;
      default:           cmd_o.cls = CLS_DELTA;
    endcase
  end

endmodule

@@ sv/dpsd_queue.sv @@
// short command queue between front end and back end
module dpsd_queue
  import dpsd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ sv/dpsd_back.sv @@
// back end: dive state, result slot sequencing and output register
module dpsd_back
  import dpsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  // configuration
  logic [7:0] interval_q;
  logic       gauge_q;
  logic [7:0] first_o2_q;

  // dive state
  logic [15:0]          run_depth_q, run_depth_d;
  logic [15:0]          max_depth_q, max_depth_d;
  logic [23:0]          elapsed_q, elapsed_d;
  logic [23:0]          dive_time_q, dive_time_d;
  logic                 sample_done_q, sample_done_d;
  logic                 await_o2_q, await_o2_d;
  logic [7:0]           gas_tab_q [MAX_GAS_MIXES];
  logic [7:0]           gas_tab_d [MAX_GAS_MIXES];
  logic [GAS_CNT_W-1:0] gas_cnt_q, gas_cnt_d;
  logic                 rec_done_q, rec_done_d;

  // pending slots and their payload
  logic [NUM_SLOTS-1:0] mask_q, mask_d, mask_new;
  logic                 depth_zero_q, depth_zero_d;
  event_e               ev_code_q, ev_code_d;
  logic [GAS_IDX_W-1:0] gas_idx_q, gas_idx_d;
  error_e               err_q, err_d;

  logic      out_valid_q;
  out_word_t out_q, out_d;

  slot_e                slot;
  logic                 have_slot;
  logic                 last_slot;
  logic                 out_load;
  logic                 xfer;
  logic                 take;
  logic                 hit;
  logic [GAS_IDX_W-1:0] hit_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= SAMPLE_INTERVAL_RST;
      gauge_q    <= 1'b0;
      first_o2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SAMPLE_INTERVAL: interval_q <= cfg_wdata_i;
        CFG_GAUGE_MODE:      gauge_q    <= cfg_wdata_i[0];
        CFG_FIRST_OXYGEN:    first_o2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // slot selection
  always_comb begin
    slot = S_TIME0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        slot = slot_e'(i);
      end
    end
  end

  assign have_slot = (mask_q != '0);
  assign last_slot = ((mask_q & (mask_q - 1'b1)) == '0);
  assign out_load  = !out_valid_q | out_ready_i;
  assign xfer      = out_load & have_slot;
  assign take      = cmd_valid_i & (!have_slot | (xfer & last_slot));
  assign cmd_pop_o = take;

  // decode of the command at the head of the queue
  always_comb begin
    run_depth_d   = run_depth_q;
    max_depth_d   = max_depth_q;
    elapsed_d     = elapsed_q;
    dive_time_d   = dive_time_q;
    sample_done_d = sample_done_q;
    await_o2_d    = await_o2_q;
    gas_tab_d     = gas_tab_q;
    gas_cnt_d     = gas_cnt_q;
    rec_done_d    = rec_done_q;
    mask_new      = '0;
    depth_zero_d  = 1'b0;
    ev_code_d     = cmd_i.ev_code;
    gas_idx_d     = '0;
    err_d         = ERR_NO_END;
    hit           = 1'b0;
    hit_idx       = '0;

    if (cmd_i.first_byte) begin
      run_depth_d        = '0;
      max_depth_d        = '0;
      elapsed_d          = '0;
      dive_time_d        = '0;
      sample_done_d      = 1'b1;
      await_o2_d         = 1'b0;
      gas_tab_d[0]       = (first_o2_q != '0) ? first_o2_q : AIR_OXYGEN;
      gas_cnt_d          = GAS_CNT_W'(1);
      rec_done_d         = 1'b0;
      mask_new[S_TIME0]  = 1'b1;
      mask_new[S_DEPTH0] = 1'b1;
      mask_new[S_GAS0]   = !gauge_q;
    end

    for (int i = MAX_GAS_MIXES - 1; i >= 0; i--) begin
      if ((GAS_CNT_W'(i) < gas_cnt_q) && (gas_tab_q[i] == cmd_i.data_byte)) begin
        hit     = 1'b1;
        hit_idx = GAS_IDX_W'(i);
      end
    end

    if (!rec_done_d) begin
      if (await_o2_d) begin
        await_o2_d = 1'b0;
        if (hit) begin
          gas_idx_d       = hit_idx;
          mask_new[S_GAS] = 1'b1;
        end else if (gas_cnt_q >= GAS_CNT_W'(MAX_GAS_MIXES)) begin
          err_d             = ERR_GAS_FULL;
          mask_new[S_ERROR] = 1'b1;
          rec_done_d        = 1'b1;
        end else begin
          gas_tab_d[gas_cnt_q[GAS_IDX_W-1:0]] = cmd_i.data_byte;
          gas_cnt_d       = gas_cnt_q + 1'b1;
          gas_idx_d       = gas_cnt_q[GAS_IDX_W-1:0];
          mask_new[S_GAS] = 1'b1;
        end
      end else begin
        if (sample_done_d) begin
          elapsed_d        = elapsed_d + 24'(interval_q);
          sample_done_d    = 1'b0;
          mask_new[S_TIME] = 1'b1;
        end
        case (cmd_i.cls)
          CLS_END: begin
            depth_zero_d        = 1'b1;
            mask_new[S_DEPTH]   = 1'b1;
            mask_new[S_SUMMARY] = 1'b1;
            rec_done_d          = 1'b1;
          end
          CLS_DELTA: begin
            run_depth_d = run_depth_d + {{8{cmd_i.data_byte[7]}}, cmd_i.data_byte};
            if (run_depth_d > max_depth_d) begin
              max_depth_d = run_depth_d;
            end
            dive_time_d       = dive_time_d + 24'(interval_q);
            sample_done_d     = 1'b1;
            mask_new[S_DEPTH] = 1'b1;
          end
          CLS_EVENT: mask_new[S_EVENT] = 1'b1;
          CLS_GAS_CHANGE: begin
            if (cmd_i.buffer_end) begin
              err_d             = ERR_TRUNC_GAS;
              mask_new[S_ERROR] = 1'b1;
              rec_done_d        = 1'b1;
            end else begin
              await_o2_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.buffer_end && !rec_done_d) begin
        err_d             = ERR_NO_END;
        mask_new[S_ERROR] = 1'b1;
        rec_done_d        = 1'b1;
      end
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (take) begin
      mask_d = mask_new;
    end else if (xfer) begin
      mask_d = mask_q & ~(NUM_SLOTS'(1) << slot);
    end
  end

  // result word of the current slot
  always_comb begin
    out_d             = '0;
    out_d.last_result = last_slot;
    case (slot)
      S_TIME0:  out_d.kind = KIND_TIME;
      S_DEPTH0: out_d.kind = KIND_DEPTH;
      S_GAS0:   out_d.kind = KIND_GAS;
      S_TIME: begin
        out_d.kind         = KIND_TIME;
        out_d.time_seconds = elapsed_q;
      end
      S_DEPTH: begin
        out_d.kind       = KIND_DEPTH;
        out_d.depth_feet = depth_zero_q ? '0 : $signed(run_depth_q);
      end
      S_EVENT: begin
        out_d.kind       = KIND_EVENT;
        out_d.event_code = ev_code_q;
      end
      S_GAS: begin
        out_d.kind      = KIND_GAS;
        out_d.gas_index = 2'(gas_idx_q);
      end
      S_SUMMARY: begin
        out_d.kind         = KIND_SUMMARY;
        out_d.time_seconds = dive_time_q;
        out_d.depth_feet   = $signed(max_depth_q);
      end
      S_ERROR: begin
        out_d.kind       = KIND_ERROR;
        out_d.error_code = err_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_depth_q   <= '0;
      max_depth_q   <= '0;
      elapsed_q     <= '0;
      dive_time_q   <= '0;
      sample_done_q <= 1'b1;
      await_o2_q    <= 1'b0;
      gas_cnt_q     <= GAS_CNT_W'(1);
      rec_done_q    <= 1'b1;
      mask_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (take) begin
        run_depth_q   <= run_depth_d;
        max_depth_q   <= max_depth_d;
        elapsed_q     <= elapsed_d;
        dive_time_q   <= dive_time_d;
        sample_done_q <= sample_done_d;
        await_o2_q    <= await_o2_d;
        gas_cnt_q     <= gas_cnt_d;
        rec_done_q    <= rec_done_d;
      end
      if (out_load) begin
        out_valid_q <= have_slot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      gas_tab_q    <= gas_tab_d;
      depth_zero_q <= depth_zero_d;
      ev_code_q    <= ev_code_d;
      gas_idx_q    <= gas_idx_d;
      err_q        <= err_d;
    end
    if (xfer) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTH
  a_done_not_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_done_q |-> !await_o2_q)
    else $error("oxygen byte pending on a finished record");

  a_gas_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gas_cnt_q != '0) && (gas_cnt_q <= GAS_CNT_W'(MAX_GAS_MIXES)))
    else $error("gas mix count out of range");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_word_o.last_result |=> out_valid_o)
    else $error("result burst broken before its last word");

  a_pop_only_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (mask_q == '0) || ((mask_q & (mask_q - 1'b1)) == '0 && xfer))
    else $error("command taken while results still pending");
`endif

endmodule

@@ sv/dive_profile_sample_decoder.sv @@
// top level of the dive profile sample decoder
//
// Profile bytes of one dive record enter one word per cycle on the input
// channel (valid/ready); first_byte marks the first byte of a record and
// restarts the running state. Result words leave on the output channel
// (valid/ready), one per cycle, with last_result set on the final word
// caused by an input byte; a byte may cause zero to six words.
// Configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i while no byte is in flight.
// An accepted byte is registered in the command queue, its result slots in
// the back end's pending-slot mask and each result word in the output
// register. The back end sends the words of a byte one at a time and takes
// the next byte with the last one; a plain depth sample gives a time and a
// depth word, and the two-entry queue accepts bytes meanwhile until full.
// Reset leaves all channels empty and no record open: bytes without
// first_byte are dropped until a record starts. When the receiver stalls,
// the output register holds its word, the back end stops, the queue fills
// and in_ready_o drops.
module dive_profile_sample_decoder
  import dpsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_word_o
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic head_valid;
  logic head_pop;

  dpsd_front u_front (
    .in_word_i (in_word_i),
    .cmd_o     (front_cmd)
  );

  dpsd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (head_valid),
    .pop_i        (head_pop),
    .pop_cmd_o    (head_cmd)
  );

  dpsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (head_valid),
    .cmd_pop_o   (head_pop),
    .cmd_i       (head_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
